FILE: rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sre_pkg.sv
// shared widths, op codes and controller/datapath structs
`default_nettype none

package sre_pkg;

  localparam int OP_W   = 2;
  localparam int SYM_W  = 8;
  localparam int IDX_W  = 3;
  localparam int POS_W  = 3;
  localparam int LEN_W  = 4;
  localparam int ACT_W  = 4;

  // most output beats produced for one symbol
  localparam int OUT_CAP = 64;
  localparam int CNT_W   = $clog2(OUT_CAP + 1);

  localparam logic [OP_W-1:0] OP_REWRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_RULE    = 2'd1;
  localparam logic [OP_W-1:0] OP_CHAR    = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic wr_rule;
    logic wr_char;
    logic hit;
    logic text_start;
    logic k_next;
    logic rule_next;
    logic push;
    logic finish;
    logic flush;
  } sre_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_rewrite;
    logic op_rule;
    logic op_char;
    logic scan_done;
    logic hit;
    logic has_text;
    logic text_last;
    logic cap_full;
    logic pend_valid;
    logic out_free;
  } sre_status_t;

endpackage

`default_nettype wire

FILE: rtl/sre_in_if.sv
// input channel: rewrite and rule load items
`default_nettype none

interface sre_in_if import sre_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [SYM_W-1:0] symbol;
  logic [IDX_W-1:0] rule_index;
  logic [POS_W-1:0] char_pos;
  logic [LEN_W-1:0] rule_length;

  modport source (output valid, op, symbol, rule_index, char_pos, rule_length,
                  input ready);
  modport sink (input valid, op, symbol, rule_index, char_pos, rule_length,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/sre_out_if.sv
// output channel: rewritten characters
`default_nettype none

interface sre_out_if import sre_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] out_symbol;
  logic             last;

  modport source (output valid, out_symbol, last, input ready);
  modport sink (input valid, out_symbol, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/sre_datapath.sv
// rule tables, replacement text memory, scan counters and output register
`default_nettype none

module sre_datapath import sre_pkg::*; #(
  parameter int RULES   = 8,
  parameter int MAX_LEN = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  sre_cmd_t          cmd,
  output sre_status_t       st,
  input  logic              cfg_we,
  input  logic [ACT_W-1:0]  cfg_data,
  input  logic [OP_W-1:0]   op,
  input  logic [SYM_W-1:0]  symbol,
  input  logic [IDX_W-1:0]  rule_index,
  input  logic [POS_W-1:0]  char_pos,
  input  logic [LEN_W-1:0]  rule_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SYM_W-1:0]  out_symbol,
  output logic              out_last
);

  localparam int RIW   = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int RCW   = $clog2(RULES + 1);
  localparam int LW    = $clog2(MAX_LEN + 1);
  localparam int DEPTH = RULES * MAX_LEN;
  localparam int TAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SYM_W-1:0] src_tab [RULES];
  logic [LW-1:0]    len_tab [RULES];
  logic [SYM_W-1:0] text_mem [DEPTH];

  logic [ACT_W-1:0] active;
  logic [SYM_W-1:0] sym;
  logic [RCW-1:0]   r;
  logic [LW-1:0]    k;
  logic [CNT_W-1:0] n;
  logic             matched;
  logic             pend_valid;
  logic [SYM_W-1:0] pend_char;
  logic [SYM_W-1:0] rd_data;

  logic [RCW-1:0]   limit;
  logic [RIW-1:0]   rule_sel;
  logic [TAW-1:0]   rd_addr;
  logic [TAW-1:0]   wr_addr;
  logic             idx_ok;
  logic             pos_ok;
  logic [LW-1:0]    len_sat;
  logic             cap_full;
  logic             out_free;
  logic             out_load;

  // table addressing and saturation
  assign limit    = (int'(active) > RULES) ? RCW'(RULES) : RCW'(active);
  assign rule_sel = r[RIW-1:0];
  assign rd_addr  = TAW'(rule_sel * MAX_LEN + k);
  assign wr_addr  = TAW'(RIW'(rule_index) * MAX_LEN + char_pos);
  assign idx_ok   = int'(rule_index) < RULES;
  assign pos_ok   = int'(char_pos) < MAX_LEN;
  assign len_sat  = (int'(rule_length) > MAX_LEN) ? LW'(MAX_LEN) : LW'(rule_length);
  assign cap_full = (n == CNT_W'(OUT_CAP));
  assign out_free = !out_valid || out_ready;
  assign out_load = (cmd.push && !cap_full && pend_valid) || cmd.flush;

  // status back to the controller
  always_comb begin
    st            = '0;
    st.op_rewrite = (op == OP_REWRITE);
    st.op_rule    = (op == OP_RULE);
    st.op_char    = (op == OP_CHAR);
    st.scan_done  = (r == limit);
    st.hit        = (src_tab[rule_sel] == sym);
    st.has_text   = (len_tab[rule_sel] != '0);
    st.text_last  = ((k + LW'(1)) >= len_tab[rule_sel]);
    st.cap_full   = cap_full;
    st.pend_valid = pend_valid;
    st.out_free   = out_free;
  end

  // active rule count
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cfg_we) begin
      active <= cfg_data;
    end
  end

  // rule source and length table
  always_ff @(posedge clk) begin
    if (cmd.wr_rule && idx_ok) begin
      src_tab[RIW'(rule_index)] <= symbol;
      len_tab[RIW'(rule_index)] <= len_sat;
    end
  end

  // replacement text memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_char && idx_ok && pos_ok) begin
      text_mem[wr_addr] <= symbol;
    end
    rd_data <= text_mem[rd_addr];
  end

  // scan control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      r       <= '0;
      k       <= '0;
      n       <= '0;
      matched <= 1'b0;
    end else begin
      if (cmd.start) begin
        r       <= '0;
        n       <= '0;
        matched <= 1'b0;
      end
      if (cmd.hit) begin
        matched <= 1'b1;
      end
      if (cmd.text_start) begin
        k <= '0;
      end else if (cmd.k_next) begin
        k <= k + LW'(1);
      end
      if (cmd.rule_next) begin
        r <= r + RCW'(1);
      end
      if (cmd.push && !cap_full) begin
        n <= n + CNT_W'(1);
      end
    end
  end

  // held symbol for the start of a rewrite
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sym <= symbol;
    end
  end

  // one character held back until it is known whether it is the last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.push && !cap_full) begin
      pend_valid <= 1'b1;
    end else if (cmd.finish && !matched) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !cap_full) begin
      pend_char <= rd_data;
    end else if (cmd.finish && !matched) begin
      pend_char <= sym;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_symbol <= pend_char;
      out_last   <= cmd.flush;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sre_controller.sv
// sequencing state machine for rule scan, text read and output flush
`default_nettype none

module sre_controller import sre_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  sre_status_t st,
  output sre_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_PUSH  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.start   = in_valid && st.op_rewrite;
        cmd.wr_rule = in_valid && st.op_rule;
        cmd.wr_char = in_valid && st.op_char;
        if (in_valid && st.op_rewrite) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.scan_done) begin
          cmd.finish = 1'b1;
          state_next = S_FLUSH;
        end else if (st.hit) begin
          cmd.hit = 1'b1;
          if (st.has_text) begin
            cmd.text_start = 1'b1;
            state_next     = S_READ;
          end else begin
            cmd.rule_next = 1'b1;
          end
        end else begin
          cmd.rule_next = 1'b1;
        end
      end
      S_READ: begin
        state_next = S_PUSH;
      end
      S_PUSH: begin
        // a held character moves out only when the output register is free
        if (st.cap_full || !st.pend_valid || st.out_free) begin
          cmd.push = 1'b1;
          if (st.text_last) begin
            cmd.rule_next = 1'b1;
            state_next    = S_SCAN;
          end else begin
            cmd.k_next = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_FLUSH: begin
        if (!st.pend_valid) begin
          state_next = S_IDLE;
        end else if (st.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/symbol_rewrite_expander.sv
// a rule or character load is written while the block is idle; a rewrite scans
// the active rules in turn, with a text memory read and a push for each character
// of a matching rule, then a flush, and waits longer while the output side stalls.
// one item is in work at a time; the output register lets the next item enter
// while the final beat still waits. synchronous active-high reset clears the
// controller, the output register and the active rule count; rule tables are not cleared.
`default_nettype none
`include "assert_macros.svh"

module symbol_rewrite_expander import sre_pkg::*; #(
  parameter int RULES   = 8,
  parameter int MAX_LEN = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [ACT_W-1:0] cfg_data,
  sre_in_if.sink           symbols,
  sre_out_if.source        expanded
);

  sre_cmd_t    cmd;
  sre_status_t st;
  logic        in_ready;
  logic        out_valid;
  logic [SYM_W-1:0] out_symbol;
  logic        out_last;

  assign symbols.ready       = in_ready;
  assign expanded.valid      = out_valid;
  assign expanded.out_symbol = out_symbol;
  assign expanded.last       = out_last;

  // control
  sre_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (symbols.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // tables and output
  sre_datapath #(
    .RULES   (RULES),
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .op          (symbols.op),
    .symbol      (symbols.symbol),
    .rule_index  (symbols.rule_index),
    .char_pos    (symbols.char_pos),
    .rule_length (symbols.rule_length),
    .out_valid   (out_valid),
    .out_ready   (expanded.ready),
    .out_symbol  (out_symbol),
    .out_last    (out_last)
  );

  // checks
  `ASSERT_RUN(a_no_pend_on_accept, (symbols.valid && symbols.ready) |-> !st.pend_valid, "item accepted with a character still held")
  `ASSERT_RUN(a_push_needs_room, (cmd.push && st.pend_valid && !st.cap_full) |-> st.out_free, "held character pushed over an untaken beat")
  `ASSERT_RUN(a_flush_needs_room, cmd.flush |-> (st.out_free && st.pend_valid), "flush without a held character or a free output")
  `ASSERT_ALL(a_quiet_after_reset, rst |=> !expanded.valid, "output beat valid right after reset")

endmodule

`default_nettype wire

FILE: tb/sv/sre_expand_checker.sv
// checker for symbol_rewrite_expander: predicts output beats from accepted items and compares
`timescale 1ns / 100ps

module sre_expand_checker import sre_pkg::*; #(
  parameter int RULES   = 8,
  parameter int MAX_LEN = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [ACT_W-1:0] cfg_data,
  sre_in_if                symbols,
  sre_out_if               expanded,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [SYM_W-1:0] out_symbol;
    logic             last;
  } beat_t;

  // shadow copy of the rule table and the active rule count
  logic [SYM_W-1:0] rule_src [RULES];
  logic [LEN_W-1:0] rule_len [RULES];
  logic [SYM_W-1:0] rule_txt [RULES*MAX_LEN];
  logic [ACT_W-1:0] active_cnt;

  beat_t expected_beats [$];

  // one generation of rewriting for a single symbol, appended to the expected beats
  function automatic void queue_expansion(input logic [SYM_W-1:0] sym);
    logic [SYM_W-1:0] chars [$];
    int               n_rules;
    bit               hit;
    beat_t            b;
    n_rules = (int'(active_cnt) > RULES) ? RULES : int'(active_cnt);
    hit = 1'b0;
    for (int r = 0; r < n_rules; r++) begin
      if (rule_src[r] == sym) begin
        hit = 1'b1;
        for (int k = 0; k < int'(rule_len[r]); k++) begin
          if (chars.size() < OUT_CAP) chars.push_back(rule_txt[r*MAX_LEN + k]);
        end
      end
    end
    // no matching rule: the symbol passes through unchanged
    if (!hit) chars.push_back(sym);
    for (int i = 0; i < chars.size(); i++) begin
      b.out_symbol = chars[i];
      b.last       = (i == chars.size() - 1);
      expected_beats.push_back(b);
    end
  endfunction

  // table loads and rewrites
  function automatic void apply_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                     input logic [IDX_W-1:0] idx, input logic [POS_W-1:0] pos,
                                     input logic [LEN_W-1:0] len);
    case (op)
      OP_REWRITE: begin
        queue_expansion(sym);
      end
      OP_RULE: begin
        if (int'(idx) < RULES) begin
          rule_src[idx] = sym;
          rule_len[idx] = (int'(len) > MAX_LEN) ? LEN_W'(MAX_LEN) : len;
        end
      end
      OP_CHAR: begin
        if (int'(idx) < RULES && int'(pos) < MAX_LEN) rule_txt[int'(idx)*MAX_LEN + int'(pos)] = sym;
      end
      default: ;
    endcase
  endfunction

  // compare one output beat with the oldest expectation
  function automatic void check_beat(input logic [SYM_W-1:0] sym, input logic last);
    beat_t want;
    if (expected_beats.size() == 0) begin
      $error("out beat with nothing expected: out_symbol %0h last %0b", sym, last);
      fail_count++;
    end else begin
      want = expected_beats.pop_front();
      if (want.out_symbol !== sym) begin
        $error("out_symbol: expected %0h, actual %0h", want.out_symbol, sym);
        fail_count++;
      end
      if (want.last !== last) begin
        $error("last: expected %0b, actual %0b", want.last, last);
        fail_count++;
      end
    end
  endfunction

  // sample both channels and the register port at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      active_cnt = '0;
    end else begin
      if (expanded.valid && expanded.ready) check_beat(expanded.out_symbol, expanded.last);
      if (symbols.valid && symbols.ready) begin
        apply_item(symbols.op, symbols.symbol, symbols.rule_index, symbols.char_pos,
                   symbols.rule_length);
      end
      if (cfg_we) active_cnt = cfg_data;
    end
    pending = expected_beats.size();
  end

endmodule

FILE: tb/sv/symbol_rewrite_expander_test.sv
// testbench top for symbol_rewrite_expander: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module symbol_rewrite_expander_test;
  import sre_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // settling wait, long enough for a rewrite that yields no beat and for loads
  localparam int SETTLE = 20;
  // longest rewrite: 8 rules scanned, 64 characters read and pushed, flush
  localparam int TAIL   = 150;
  localparam int LIMIT  = 3_000_000;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [ACT_W-1:0] cfg_data;
  int               fail_count;
  int               pending;
  logic [SYM_W-1:0] src_pool [4];

  sre_in_if  symbols ();
  sre_out_if expanded ();

  symbol_rewrite_expander dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .symbols  (symbols.sink),
    .expanded (expanded.source)
  );

  sre_expand_checker beat_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .symbols    (symbols),
    .expanded   (expanded),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("symbol_rewrite_expander_test: FAIL");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // symbols drawn mostly from the rule source pool so that rules match
  function automatic logic [SYM_W-1:0] pick_symbol();
    if ($urandom_range(0, 3) != 0) return src_pool[$urandom_range(0, 3)];
    return SYM_W'($urandom_range(0, 255));
  endfunction

  // output side stalls
  initial begin
    int hold;
    int stall;
    bit open;
    hold = 0;
    open = 1'b0;
    expanded.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        stall = open ? pick_gap() : 0;
        if (stall > 0) begin
          open = 1'b0;
          hold = stall - 1;
        end else begin
          open = 1'b1;
          hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(0, 30);
        end
        expanded.ready <= open;
      end
    end
  end

  // wait until every expected beat is out and the block has settled
  task automatic drain();
    @(negedge clk);
    symbols.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // one input beat; returns right after the accepting edge
  task automatic push_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                           input logic [IDX_W-1:0] idx, input logic [POS_W-1:0] pos,
                           input logic [LEN_W-1:0] len);
    int gap;
    if ($urandom_range(0, 99) < 3) drain();
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      symbols.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    symbols.valid       <= 1'b1;
    symbols.op          <= op;
    symbols.symbol      <= sym;
    symbols.rule_index  <= idx;
    symbols.char_pos    <= pos;
    symbols.rule_length <= len;
    @(posedge clk);
    while (!symbols.ready) @(posedge clk);
  endtask

  // unused fields carry random values
  task automatic rewrite(input logic [SYM_W-1:0] sym);
    push_item(OP_REWRITE, sym, IDX_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 7)),
              LEN_W'($urandom_range(0, 15)));
  endtask

  task automatic load_rule(input logic [IDX_W-1:0] idx, input logic [SYM_W-1:0] src,
                           input logic [LEN_W-1:0] len);
    push_item(OP_RULE, src, idx, POS_W'($urandom_range(0, 7)), len);
  endtask

  task automatic load_char(input logic [IDX_W-1:0] idx, input logic [POS_W-1:0] pos,
                           input logic [SYM_W-1:0] ch);
    push_item(OP_CHAR, ch, idx, pos, LEN_W'($urandom_range(0, 15)));
  endtask

  task automatic write_active(input logic [ACT_W-1:0] value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // stimulus
  initial begin
    int counted;
    int pick;
    int phase_active [9];
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    symbols.valid       = 1'b0;
    symbols.op          = OP_REWRITE;
    symbols.symbol      = '0;
    symbols.rule_index  = '0;
    symbols.char_pos    = '0;
    symbols.rule_length = '0;
    phase_active = '{8, 3, 0, 15, 8, 1, 6, 9, 12};
    phase_active[6] = $urandom_range(0, 15);

    // pool of rule sources, kept clear of the directed no-match and extreme symbols
    src_pool[0] = 8'hAA;
    for (int i = 1; i < 4; i++) begin
      do src_pool[i] = SYM_W'($urandom_range(1, 254));
      while (src_pool[i] == 8'h5A || src_pool[i] == 8'hAA);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill every table entry while no rule is active, so no rewrite reads an unwritten entry
    for (int r = 0; r < 8; r++) begin
      load_rule(IDX_W'(r), src_pool[r % 4], LEN_W'($urandom_range(0, 8)));
      for (int p = 0; p < 8; p++) begin
        load_char(IDX_W'(r), POS_W'(p), SYM_W'($urandom_range(0, 255)));
      end
    end

    // directed: overlong length, zero and extreme characters, empty rules, no match
    write_active(4'd8);
    load_rule(3'd0, 8'hFF, 4'd15);
    load_char(3'd0, 3'd0, 8'h00);
    load_char(3'd0, 3'd7, 8'hFF);
    load_rule(3'd7, 8'hFF, 4'd0);
    load_rule(3'd3, 8'h00, 4'd0);
    rewrite(8'hFF);
    rewrite(8'h00);
    rewrite(8'h5A);
    push_item(OP_UNUSED, 8'hFF, 3'd7, 3'd7, 4'd15);
    load_rule(3'd4, 8'hFF, 4'd8);
    rewrite(8'hFF);
    // every rule full and matching: 64 beats for one symbol
    for (int r = 0; r < 8; r++) load_rule(IDX_W'(r), 8'hAA, 4'd8);
    rewrite(8'hAA);
    rewrite(8'hAA);
    write_active(4'd0);
    rewrite(8'hAA);
    write_active(4'd15);
    rewrite(8'hAA);
    write_active(4'd1);
    rewrite(8'hAA);

    // random phases, one active count each
    for (int ph = 0; ph < 9; ph++) begin
      write_active(ACT_W'(phase_active[ph]));
      counted = 0;
      while (counted < 15) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          rewrite(pick_symbol());
          counted++;
        end else if (pick < 75) begin
          load_rule(IDX_W'($urandom_range(0, 7)), pick_symbol(),
                    LEN_W'(($urandom_range(0, 4) == 0) ? $urandom_range(9, 15)
                                                       : $urandom_range(0, 8)));
          counted++;
        end else if (pick < 95) begin
          load_char(IDX_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 7)),
                    SYM_W'($urandom_range(0, 255)));
          counted++;
        end else begin
          push_item(OP_UNUSED, SYM_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 7)),
                    POS_W'($urandom_range(0, 7)), LEN_W'($urandom_range(0, 15)));
        end
      end
    end

    drain();
    repeat (TAIL) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("symbol_rewrite_expander_test: PASS");
    end else begin
      $display("symbol_rewrite_expander_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/sre_pkg.sv
rtl/sre_in_if.sv
rtl/sre_out_if.sv
rtl/sre_datapath.sv
rtl/sre_controller.sv
rtl/symbol_rewrite_expander.sv
tb/sv/sre_expand_checker.sv
tb/sv/symbol_rewrite_expander_test.sv
